// ----- rtl/core/cepth_pkg.sv -----
`default_nettype none

package cepth_pkg;

  localparam int unsigned INT_W   = 8;
  localparam int unsigned SPAN_W  = 12;
  localparam int unsigned POS_W   = 12;
  localparam int unsigned TALLY_W = 13;
  localparam int unsigned ADDR_W  = 3;
  localparam int unsigned DATA_W  = 32;

  localparam logic [TALLY_W-1:0] TALLY_MAX  = 13'h1FFF;
  localparam logic [INT_W-1:0]   THR_RESET  = 8'd150;
  localparam logic [SPAN_W-1:0]  SPAN_RESET = 12'd100;

  localparam logic [ADDR_W-1:0] ADDR_THRESHOLD = 3'd0;
  localparam logic [ADDR_W-1:0] ADDR_MIN_SPAN  = 3'd4;

  typedef enum logic [1:0] {
    MARK_NONE  = 2'd0,
    MARK_START = 2'd1,
    MARK_END   = 2'd2
  } mark_t;

  typedef struct packed {
    logic [INT_W-1:0] intensity;
    logic             column_end;
    logic             frame_start;
  } item_t;

  typedef struct packed {
    logic [INT_W-1:0]  threshold;
    logic [SPAN_W-1:0] min_span;
  } cfg_t;

  typedef struct packed {
    mark_t              edge_mark;
    logic               report_valid;
    logic [POS_W-1:0]   report_column;
    logic [POS_W-1:0]   start_row;
    logic [POS_W-1:0]   end_row;
    logic [TALLY_W-1:0] span_count;
  } res_t;

endpackage

`default_nettype wire

// ----- rtl/core/cepth_if.sv -----
`default_nettype none

interface cepth_in_if;
  logic                          valid;
  logic                          ready;
  logic [cepth_pkg::INT_W-1:0]   intensity;
  logic                          column_end;
  logic                          frame_start;

  modport source (output valid, intensity, column_end, frame_start, input ready);
  modport sink   (input valid, intensity, column_end, frame_start, output ready);
endinterface

interface cepth_out_if;
  logic                          valid;
  logic                          ready;
  logic [1:0]                    edge_mark;
  logic                          report_valid;
  logic [cepth_pkg::POS_W-1:0]   report_column;
  logic [cepth_pkg::POS_W-1:0]   start_row;
  logic [cepth_pkg::POS_W-1:0]   end_row;
  logic [cepth_pkg::TALLY_W-1:0] span_count;

  modport source (output valid, edge_mark, report_valid, report_column, start_row, end_row,
                  span_count, input ready);
  modport sink   (input valid, edge_mark, report_valid, report_column, start_row, end_row,
                  span_count, output ready);
endinterface

`default_nettype wire

// ----- rtl/core/cepth_regs.sv -----
`default_nettype none

module cepth_regs (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           psel,
  input  logic                           penable,
  input  logic                           pwrite,
  input  logic [cepth_pkg::ADDR_W-1:0]   paddr,
  input  logic [cepth_pkg::DATA_W-1:0]   pwdata,
  output logic [cepth_pkg::DATA_W-1:0]   prdata,
  output logic                           pready,
  output cepth_pkg::cfg_t                cfg
);

  logic [cepth_pkg::INT_W-1:0]  thr_r;
  logic [cepth_pkg::SPAN_W-1:0] span_r;
  logic                         wr_en;

  assign pready = 1'b1;
  assign wr_en  = psel & penable & pwrite;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      thr_r  <= cepth_pkg::THR_RESET;
      span_r <= cepth_pkg::SPAN_RESET;
    end else if (wr_en) begin
      unique case (paddr)
        cepth_pkg::ADDR_THRESHOLD: thr_r  <= pwdata[cepth_pkg::INT_W-1:0];
        default:                   span_r <= pwdata[cepth_pkg::SPAN_W-1:0];
      endcase
    end
  end

  always_comb begin
    unique case (paddr)
      cepth_pkg::ADDR_THRESHOLD:
        prdata = {{(cepth_pkg::DATA_W-cepth_pkg::INT_W){1'b0}}, thr_r};
      default:
        prdata = {{(cepth_pkg::DATA_W-cepth_pkg::SPAN_W){1'b0}}, span_r};
    endcase
  end

  assign cfg.threshold = thr_r;
  assign cfg.min_span  = span_r;

`ifndef SYNTHESIS
  a_thr_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && paddr == cepth_pkg::ADDR_THRESHOLD |=>
      thr_r == $past(pwdata[cepth_pkg::INT_W-1:0]) && $stable(span_r))
    else $error("threshold write lost or disturbed span");
  a_span_write: assert property (@(posedge clk) disable iff (!rst_n)
    wr_en && paddr != cepth_pkg::ADDR_THRESHOLD |=>
      span_r == $past(pwdata[cepth_pkg::SPAN_W-1:0]) && $stable(thr_r))
    else $error("span write lost or disturbed threshold");
  a_hold: assert property (@(posedge clk) disable iff (!rst_n)
    !wr_en |=> $stable(thr_r) && $stable(span_r))
    else $error("config changed without write");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/cepth_core.sv -----
`default_nettype none

module cepth_core #(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic             clk,
  input  logic             rst_n,
  input  logic             advance,
  input  cepth_pkg::item_t item,
  input  cepth_pkg::cfg_t  cfg,
  output cepth_pkg::res_t  res
);

  localparam int unsigned RW = $clog2(MAX_ROWS);
  localparam int unsigned CW = (MAX_COLUMNS > 1) ? $clog2(MAX_COLUMNS) : 1;
  localparam logic [RW-1:0] ROW_LAST = RW'(MAX_ROWS - 1);
  localparam logic [CW-1:0] COL_LAST = CW'(MAX_COLUMNS - 1);

  localparam int unsigned PW = cepth_pkg::POS_W;
  localparam int unsigned TW = cepth_pkg::TALLY_W;

  logic          la_r, la_nxt;
  logic          ss_r, ss_nxt;
  logic          es_r, es_nxt;
  logic [TW-1:0] tally_r, tally_nxt;
  logic [PW-1:0] srow_r, srow_nxt;
  logic [PW-1:0] erow_r, erow_nxt;
  logic [RW-1:0] row_r, row_nxt;
  logic [CW-1:0] col_r, col_nxt;

  logic          la_c, ss_c, es_c, la1, la2, ss1, es1, bright;
  logic [TW-1:0] tally_c, tally1;
  logic [PW-1:0] srow_c, erow_c, srow1, erow1, row12;
  logic [RW-1:0] row_c;
  logic [CW-1:0] col_c;
  logic [RW+PW-1:0] row_ext;
  logic [CW+PW-1:0] col_ext;
  cepth_pkg::mark_t mark;

  always_comb begin
    la_c    = item.frame_start ? 1'b0     : la_r;
    ss_c    = item.frame_start ? 1'b0     : ss_r;
    es_c    = item.frame_start ? 1'b0     : es_r;
    tally_c = item.frame_start ? '0       : tally_r;
    srow_c  = item.frame_start ? '0       : srow_r;
    erow_c  = item.frame_start ? '0       : erow_r;
    row_c   = item.frame_start ? '0       : row_r;
    col_c   = item.frame_start ? '0       : col_r;

    row_ext = {{PW{1'b0}}, row_c};
    row12   = row_ext[PW-1:0];
    col_ext = {{PW{1'b0}}, col_c};

    bright = item.intensity > cfg.threshold;
    la1    = la_c | bright;
    tally1 = (la1 && tally_c != cepth_pkg::TALLY_MAX) ? tally_c + TW'(1) : tally_c;

    mark  = cepth_pkg::MARK_NONE;
    ss1   = ss_c;
    srow1 = srow_c;
    if (la1 && !ss_c) begin
      ss1   = 1'b1;
      srow1 = row12;
      mark  = cepth_pkg::MARK_START;
    end

    la2   = la1;
    es1   = es_c;
    erow1 = erow_c;
    if (la1 && tally1 > {1'b0, cfg.min_span}) begin
      la2 = !bright;
      if (bright && !es_c) begin
        es1   = 1'b1;
        erow1 = row12;
        mark  = cepth_pkg::MARK_END;
      end
    end

    res           = '0;
    res.edge_mark = mark;

    if (item.column_end) begin
      res.report_valid  = es1;
      res.report_column = col_ext[PW-1:0];
      res.start_row     = srow1;
      res.end_row       = erow1;
      res.span_count    = tally1;
      la_nxt    = 1'b0;
      ss_nxt    = 1'b0;
      es_nxt    = 1'b0;
      tally_nxt = '0;
      srow_nxt  = '0;
      erow_nxt  = '0;
      row_nxt   = '0;
      col_nxt   = (col_c == COL_LAST) ? '0 : col_c + CW'(1);
    end else begin
      la_nxt    = la2;
      ss_nxt    = ss1;
      es_nxt    = es1;
      tally_nxt = tally1;
      srow_nxt  = srow1;
      erow_nxt  = erow1;
      row_nxt   = (row_c == ROW_LAST) ? row_c : row_c + RW'(1);
      col_nxt   = col_c;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      la_r    <= 1'b0;
      ss_r    <= 1'b0;
      es_r    <= 1'b0;
      tally_r <= '0;
      srow_r  <= '0;
      erow_r  <= '0;
      row_r   <= '0;
      col_r   <= '0;
    end else if (advance) begin
      la_r    <= la_nxt;
      ss_r    <= ss_nxt;
      es_r    <= es_nxt;
      tally_r <= tally_nxt;
      srow_r  <= srow_nxt;
      erow_r  <= erow_nxt;
      row_r   <= row_nxt;
      col_r   <= col_nxt;
    end
  end

`ifndef SYNTHESIS
  a_end_after_start: assert property (@(posedge clk) disable iff (!rst_n)
    es_r |-> ss_r)
    else $error("end edge held without start edge");
  a_tally_needs_start: assert property (@(posedge clk) disable iff (!rst_n)
    tally_r != '0 |-> ss_r)
    else $error("pixels counted before start edge");
  a_end_mark_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    advance && res.edge_mark == cepth_pkg::MARK_END && !item.column_end |=> es_r)
    else $error("end edge mark not recorded");
  a_column_clear: assert property (@(posedge clk) disable iff (!rst_n)
    advance && item.column_end |=> row_r == '0 && tally_r == '0 && !ss_r && !la_r)
    else $error("column state not cleared at column end");
`endif

endmodule

`default_nettype wire

// ----- rtl/core/column_edge_pair_thickness_top.sv -----
`default_nettype none
// Input words pass the input register and the core into the output register
// on out_if: one word per clock while out_if.ready stays high; a held result
// stalls the core, and input stalls once the input register is also full.
// Reset (rst_n low, synchronous): both valid flags clear, threshold = 150,
// minimum span = 100, all row and column counters and span state clear.

module column_edge_pair_thickness_top #(
  parameter int unsigned MAX_ROWS    = 4096,
  parameter int unsigned MAX_COLUMNS = 4096
) (
  input  logic                         clk,
  input  logic                         rst_n,
  cepth_in_if.sink                     in_if,
  cepth_out_if.source                  out_if,
  input  logic                         cfg_psel,
  input  logic                         cfg_penable,
  input  logic                         cfg_pwrite,
  input  logic [cepth_pkg::ADDR_W-1:0] cfg_paddr,
  input  logic [cepth_pkg::DATA_W-1:0] cfg_pwdata,
  output logic [cepth_pkg::DATA_W-1:0] cfg_prdata,
  output logic                         cfg_pready
);

  cepth_pkg::cfg_t  cfg;
  cepth_pkg::item_t in_item_r;
  cepth_pkg::res_t  res;
  cepth_pkg::res_t  out_res_r;
  logic             in_valid_r;
  logic             out_valid_r;
  logic             advance;

  cepth_regs u_regs (
    .clk     (clk),
    .rst_n   (rst_n),
    .psel    (cfg_psel),
    .penable (cfg_penable),
    .pwrite  (cfg_pwrite),
    .paddr   (cfg_paddr),
    .pwdata  (cfg_pwdata),
    .prdata  (cfg_prdata),
    .pready  (cfg_pready),
    .cfg     (cfg)
  );

  assign advance     = in_valid_r & (~out_valid_r | out_if.ready);
  assign in_if.ready = ~in_valid_r | advance;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      in_valid_r <= 1'b0;
    end else if (in_if.ready) begin
      in_valid_r <= in_if.valid;
    end
  end

  always_ff @(posedge clk) begin
    if (in_if.valid && in_if.ready) begin
      in_item_r.intensity   <= in_if.intensity;
      in_item_r.column_end  <= in_if.column_end;
      in_item_r.frame_start <= in_if.frame_start;
    end
  end

  cepth_core #(
    .MAX_ROWS    (MAX_ROWS),
    .MAX_COLUMNS (MAX_COLUMNS)
  ) u_core (
    .clk     (clk),
    .rst_n   (rst_n),
    .advance (advance),
    .item    (in_item_r),
    .cfg     (cfg),
    .res     (res)
  );

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      out_valid_r <= 1'b0;
    end else if (~out_valid_r | out_if.ready) begin
      out_valid_r <= in_valid_r;
    end
  end

  always_ff @(posedge clk) begin
    if (advance) begin
      out_res_r <= res;
    end
  end

  assign out_if.valid         = out_valid_r;
  assign out_if.edge_mark     = out_res_r.edge_mark;
  assign out_if.report_valid  = out_res_r.report_valid;
  assign out_if.report_column = out_res_r.report_column;
  assign out_if.start_row     = out_res_r.start_row;
  assign out_if.end_row       = out_res_r.end_row;
  assign out_if.span_count    = out_res_r.span_count;

endmodule

`default_nettype wire
